### rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // Default depth of the queue between the scanner and the serialiser.
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_END     = 2'd1,
    KIND_MISSING = 2'd2,
    KIND_BADLOW  = 2'd3
  } kind_t;

  // Scanner modes, one-hot.
  typedef enum logic [6:0] {
    MODE_PLAIN   = 7'b0000001,
    MODE_ESC     = 7'b0000010,
    MODE_HEX     = 7'b0000100,
    MODE_NEED_BS = 7'b0001000,
    MODE_NEED_U  = 7'b0010000,
    MODE_HEX2    = 7'b0100000,
    MODE_DISCARD = 7'b1000000
  } mode_t;

  // Characters the scanner looks for.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_B      = 8'h62;

  // One result item.
  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } entry_t;

  // All results caused by one input byte: one to four entries.
  typedef struct packed {
    entry_t [3:0] entries;
    logic   [1:0] cnt_m1;   // number of entries minus one
  } packet_t;

  // Push request from the scanner into the queue.
  typedef struct packed {
    logic    vld;
    packet_t pkt;
  } push_t;

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = 4'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h61 + 8'd10);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h41 + 8'd10);
    return v;
  endfunction

  function automatic packet_t byte_pkt(input logic [7:0] b);
    packet_t p;
    p = '0;
    p.entries[0].data = b;
    p.entries[0].kind = KIND_DATA;
    p.cnt_m1 = 2'd0;
    return p;
  endfunction

  function automatic packet_t kind_pkt(input kind_t k);
    packet_t p;
    p = '0;
    p.entries[0].kind = k;
    p.cnt_m1 = 2'd0;
    return p;
  endfunction

  function automatic packet_t missing_end_pkt();
    packet_t p;
    p = '0;
    p.entries[0].kind = KIND_MISSING;
    p.entries[1].kind = KIND_END;
    p.cnt_m1 = 2'd1;
    return p;
  endfunction

  // UTF-8 encoding of a code point of up to 21 bits.
  function automatic packet_t utf8_pkt(input logic [20:0] cp);
    packet_t p;
    p = '0;
    p.entries[0].kind = KIND_DATA;
    p.entries[1].kind = KIND_DATA;
    p.entries[2].kind = KIND_DATA;
    p.entries[3].kind = KIND_DATA;
    if (cp <= 21'h7F) begin
      p.entries[0].data = cp[7:0];
      p.cnt_m1 = 2'd0;
    end else if (cp <= 21'h7FF) begin
      p.entries[0].data = {3'b110, cp[10:6]};
      p.entries[1].data = {2'b10, cp[5:0]};
      p.cnt_m1 = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      p.entries[0].data = {4'b1110, cp[15:12]};
      p.entries[1].data = {2'b10, cp[11:6]};
      p.entries[2].data = {2'b10, cp[5:0]};
      p.cnt_m1 = 2'd2;
    end else begin
      p.entries[0].data = {5'b11110, cp[20:18]};
      p.entries[1].data = {2'b10, cp[17:12]};
      p.entries[2].data = {2'b10, cp[11:6]};
      p.entries[3].data = {2'b10, cp[5:0]};
      p.cnt_m1 = 2'd3;
    end
    return p;
  endfunction

endpackage

### rtl/jsu_in_if.sv
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one raw string body byte per transaction.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### rtl/jsu_out_if.sv
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel: one decoded byte or status code per transaction.
// ----------------------------------------------------------------------------
interface jsu_out_if
  import jsu_pkg::*;
;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  kind_t      kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

### rtl/json_string_unescape_utf8_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
//
//   Channel  Dir  Payload                     Transaction
//   in_ch    in   in_byte[7:0]                one raw string body byte
//   out_ch   out  out_byte[7:0] kind[1:0] last one decoded byte or status
//
// Rates: an input byte is taken every cycle while the packet queue has room;
// the results a byte causes (none, or one to four) leave through the serialiser
// at one per cycle while the result channel is ready, so the sustained rate is
// set by the result count.
// Reset: rst_n is synchronous and active low; it returns the scanner to plain
// text and empties the queue.
// Stalls: a stalled result channel fills the queue of QUEUE_DEPTH packets,
// after which in_ch.ready falls until a packet has been sent out.
//
// The scanner (front) decodes escapes, hex groups and surrogate pairs and
// builds the complete packet of results for a byte in the cycle the byte is
// accepted. Packets wait in the queue; the serialiser (back) walks through
// the head packet's entries and marks the final one of each with last.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_core
  import jsu_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  // Push request from the scanner and head of the queue for the serialiser.
  push_t   push;
  packet_t head;
  logic    head_vld;
  logic    q_full;
  logic    pop;

  jsu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .full     (q_full),
    .head_vld (head_vld),
    .head     (head)
  );

  jsu_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

### rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Scanner: accepts input bytes, tracks the escape state and builds the
// packet of results that each byte causes.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  jsu_in_if.sink in_ch,
  input  logic   q_full,
  output push_t  push
);

  localparam logic [5:0] HIGH_TAG = 6'b110110;  // D800..DBFF
  localparam logic [5:0] LOW_TAG  = 6'b110111;  // DC00..DFFF
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  dig_r, dig_nxt;
  logic [9:0]  hs_r, hs_nxt;
  logic [15:0] acc_shift;
  logic [7:0]  b;
  logic        accept;
  logic        emit;
  packet_t     pkt;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.in_byte;
  assign acc_shift   = {acc_r[11:0], nibble_of(b)};

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    dig_nxt  = dig_r;
    hs_nxt   = hs_r;
    emit     = 1'b0;
    pkt      = '0;
    unique case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_PLAIN;
        emit     = 1'b1;
        if (b == CH_N) pkt = byte_pkt(8'h0A);
        else if (b == CH_R) pkt = byte_pkt(8'h0D);
        else if (b == CH_T) pkt = byte_pkt(8'h09);
        else if (b == CH_F) pkt = byte_pkt(8'h0C);
        else if (b == CH_B) pkt = byte_pkt(8'h08);
        else if (b == CH_U) begin
          emit     = 1'b0;
          mode_nxt = MODE_HEX;
          acc_nxt  = '0;
          dig_nxt  = '0;
        end else pkt = byte_pkt(b);
      end
      MODE_HEX, MODE_HEX2: begin
        acc_nxt = acc_shift;
        if (dig_r != 2'd3) begin
          dig_nxt = dig_r + 2'd1;
        end else begin
          dig_nxt = '0;
          emit    = 1'b1;
          if (mode_r == MODE_HEX) begin
            if (acc_shift[15:10] == HIGH_TAG) begin
              emit     = 1'b0;
              hs_nxt   = acc_shift[9:0];
              mode_nxt = MODE_NEED_BS;
            end else begin
              pkt      = utf8_pkt(21'(acc_shift));
              mode_nxt = MODE_PLAIN;
            end
          end else if (acc_shift[15:10] != LOW_TAG) begin
            pkt      = kind_pkt(KIND_BADLOW);
            mode_nxt = MODE_DISCARD;
          end else begin
            pkt      = utf8_pkt(21'({hs_r, acc_shift[9:0]}) + SUPP_BASE);
            mode_nxt = MODE_PLAIN;
          end
        end
      end
      MODE_NEED_BS: begin
        if (b == CH_BSLASH) begin
          mode_nxt = MODE_NEED_U;
        end else if (b == CH_QUOTE) begin
          emit     = 1'b1;
          pkt      = missing_end_pkt();
          mode_nxt = MODE_PLAIN;
        end else begin
          emit     = 1'b1;
          pkt      = kind_pkt(KIND_MISSING);
          mode_nxt = MODE_DISCARD;
        end
      end
      MODE_NEED_U: begin
        if (b == CH_U) begin
          mode_nxt = MODE_HEX2;
          acc_nxt  = '0;
          dig_nxt  = '0;
        end else begin
          emit     = 1'b1;
          pkt      = kind_pkt(KIND_MISSING);
          mode_nxt = MODE_DISCARD;
        end
      end
      MODE_DISCARD: begin
        if (b == CH_QUOTE) begin
          emit     = 1'b1;
          pkt      = kind_pkt(KIND_END);
          mode_nxt = MODE_PLAIN;
        end
      end
      default: begin
        // Plain text; any stray code behaves the same way.
        mode_nxt = MODE_PLAIN;
        if (b == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end else if (b == CH_QUOTE) begin
          emit = 1'b1;
          pkt  = kind_pkt(KIND_END);
        end else begin
          emit = 1'b1;
          pkt  = byte_pkt(b);
        end
      end
    endcase
  end

  assign push.vld = accept && emit;
  assign push.pkt = pkt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
      dig_r  <= '0;
      hs_r   <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
      hs_r   <= hs_nxt;
    end
  end

  // A partial hex group only exists while a hex group is being read.
  a_digits_in_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (dig_r != 2'd0) |-> (mode_r == MODE_HEX || mode_r == MODE_HEX2))
    else $error("hex digit count set outside a hex group");

endmodule

### rtl/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short packet queue between the scanner and the serialiser.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output logic    full,
  output logic    head_vld,
  output packet_t head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  packet_t       store [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign head_vld = (count_r != '0);
  assign head     = store[rd_ptr_r];
  assign do_push  = push.vld && !full;
  assign do_pop   = pop && head_vld;

  always_ff @(posedge clk) begin
    if (do_push) store[wr_ptr_r] <= push.pkt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop) count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.vld && full))
    else $error("packet pushed into a full queue");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == CW'($past(count_r) + 1'b1)))
    else $error("queue occupancy did not follow a push");

endmodule

### rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serialiser: sends the entries of the head packet one per transaction.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_vld,
  input  packet_t    head,
  output logic       pop,
  jsu_out_if.source  out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       is_last;
  logic       take;
  entry_t     cur;

  assign cur     = head.entries[idx_r];
  assign is_last = (idx_r == head.cnt_m1);
  assign take    = out_ch.valid && out_ch.ready;
  assign pop     = take && is_last;

  assign out_ch.valid    = head_vld;
  assign out_ch.out_byte = cur.data;
  assign out_ch.kind     = cur.kind;
  assign out_ch.last     = is_last;

  always_comb begin
    idx_nxt = idx_r;
    if (take) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else        idx_r <= idx_nxt;
  end

  a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    head_vld |-> (idx_r <= head.cnt_m1))
    else $error("entry index beyond the head packet");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !head_vld |-> (idx_r == 2'd0))
    else $error("entry index not cleared with the queue empty");

endmodule

### tb/json_string_unescape_utf8_core_tb.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_core_tb
// Self-checking bench for the JSON string unescaper. It feeds string body
// bytes and works out the expected results with its own decoder model. Every
// result transaction is checked field by field against that model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescape_utf8_core_tb;
  import jsu_pkg::*;

  // Surrogate ranges of a \u value.
  localparam logic [15:0] SURR_MASK      = 16'hFC00;
  localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SUPPL_OFFSET   = 21'h10000;

  // Length of the receiver hold-off that fills the packet queue.
  localparam int HOLD_OFF_CYCLES = 60;

  // One expected result transaction.
  typedef struct {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } result_t;

  logic clk;
  logic rst_n;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bytes still to be offered, and results still to arrive, oldest first.
  logic [7:0] body_bytes_q[$];
  result_t    decoded_q[$];

  // Decoder state of the model.
  mode_t       sc_mode   = MODE_PLAIN;
  logic [15:0] sc_accum  = '0;
  logic [1:0]  sc_digits = '0;
  logic [9:0]  sc_high   = '0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  hold_off       = 1'b0;
  bit  in_taken       = 1'b0;
  int  items_sent     = 0;
  int  gen_count      = 0;
  int  n_errors       = 0;

  logic       drv_valid;
  logic [7:0] drv_byte;

  // Every input is known from time zero.
  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = 8'h00;
    out_ch.ready   = 1'b0;
  end

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    // Anything that is not a hex digit counts as zero.
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    return 4'd0;
  endfunction

  task automatic emit(input logic [7:0] data, input kind_t kind);
    result_t r;
    r.data = data;
    r.kind = kind;
    r.last = 1'b0;
    decoded_q.insert(decoded_q.size(), r);
  endtask

  // UTF-8 encoding of a code point: one to four data bytes.
  task automatic emit_utf8(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      emit(cp[7:0], KIND_DATA);
    end else if (cp <= 21'h7FF) begin
      emit({3'b110, cp[10:6]}, KIND_DATA);
      emit({2'b10, cp[5:0]}, KIND_DATA);
    end else if (cp <= 21'hFFFF) begin
      emit({4'b1110, cp[15:12]}, KIND_DATA);
      emit({2'b10, cp[11:6]}, KIND_DATA);
      emit({2'b10, cp[5:0]}, KIND_DATA);
    end else begin
      emit({5'b11110, cp[20:18]}, KIND_DATA);
      emit({2'b10, cp[17:12]}, KIND_DATA);
      emit({2'b10, cp[11:6]}, KIND_DATA);
      emit({2'b10, cp[5:0]}, KIND_DATA);
    end
  endtask

  // Advances the model by one accepted byte and queues the results it causes.
  task automatic decode_byte(input logic [7:0] b);
    int          first;
    logic [20:0] cp;
    first = decoded_q.size();
    case (sc_mode)
      MODE_ESC: begin
        sc_mode = MODE_PLAIN;
        case (b)
          CH_N: emit(8'h0A, KIND_DATA);
          CH_R: emit(8'h0D, KIND_DATA);
          CH_T: emit(8'h09, KIND_DATA);
          CH_F: emit(8'h0C, KIND_DATA);
          CH_B: emit(8'h08, KIND_DATA);
          CH_U: begin
            sc_mode   = MODE_HEX;
            sc_accum  = '0;
            sc_digits = '0;
          end
          default: emit(b, KIND_DATA);
        endcase
      end
      MODE_HEX, MODE_HEX2: begin
        sc_accum = {sc_accum[11:0], hex_value(b)};
        if (sc_digits != 2'd3) begin
          sc_digits = sc_digits + 2'd1;
        end else begin
          sc_digits = '0;
          if (sc_mode == MODE_HEX) begin
            if ((sc_accum & SURR_MASK) == HIGH_SURR_BASE) begin
              sc_high = sc_accum[9:0];
              sc_mode = MODE_NEED_BS;
            end else begin
              emit_utf8({5'd0, sc_accum});
              sc_mode = MODE_PLAIN;
            end
          end else if ((sc_accum & SURR_MASK) != LOW_SURR_BASE) begin
            emit(8'h00, KIND_BADLOW);
            sc_mode = MODE_DISCARD;
          end else begin
            cp = {1'b0, sc_high, sc_accum[9:0]} + SUPPL_OFFSET;
            emit_utf8(cp);
            sc_mode = MODE_PLAIN;
          end
        end
      end
      MODE_NEED_BS: begin
        if (b == CH_BSLASH) begin
          sc_mode = MODE_NEED_U;
        end else begin
          emit(8'h00, KIND_MISSING);
          if (b == CH_QUOTE) begin
            emit(8'h00, KIND_END);
            sc_mode = MODE_PLAIN;
          end else begin
            sc_mode = MODE_DISCARD;
          end
        end
      end
      MODE_NEED_U: begin
        if (b == CH_U) begin
          sc_mode   = MODE_HEX2;
          sc_accum  = '0;
          sc_digits = '0;
        end else begin
          emit(8'h00, KIND_MISSING);
          sc_mode = MODE_DISCARD;
        end
      end
      MODE_DISCARD: begin
        if (b == CH_QUOTE) begin
          emit(8'h00, KIND_END);
          sc_mode = MODE_PLAIN;
        end
      end
      default: begin
        sc_mode = MODE_PLAIN;
        if (b == CH_BSLASH) sc_mode = MODE_ESC;
        else if (b == CH_QUOTE) emit(8'h00, KIND_END);
        else emit(b, KIND_DATA);
      end
    endcase
    // The final result of this byte carries last.
    if (decoded_q.size() > first) begin
      decoded_q[decoded_q.size() - 1].last = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b);
    body_bytes_q.insert(body_bytes_q.size(), b);
    gen_count++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'("0" + v);
    if ($urandom_range(1) == 0) return 8'("a" + v - 8'd10);
    return 8'("A" + v - 8'd10);
  endfunction

  // Any byte that is neither a quote nor a backslash.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(255));
    return b;
  endfunction

  // Four hex digits; with junk set, a digit is now and then a stray byte.
  task automatic push_hex4(input logic [15:0] v, input bit junk);
    for (int i = 3; i >= 0; i--) begin
      if (junk && $urandom_range(15) == 0) push_byte(8'($urandom_range(255)));
      else push_byte(hex_char(v[i*4 +: 4]));
    end
  endtask

  task automatic push_escape_u(input logic [15:0] v, input bit junk);
    push_byte(CH_BSLASH);
    push_byte(CH_U);
    push_hex4(v, junk);
  endtask

  // Up to four discarded bytes, any quote turned into a backslash, then the closing quote.
  task automatic push_junk_to_quote();
    int n;
    logic [7:0] b;
    n = $urandom_range(4);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(255));
      if (b == CH_QUOTE) b = CH_BSLASH;
      push_byte(b);
    end
    push_byte(CH_QUOTE);
  endtask

  function automatic logic [15:0] rand_high();
    return HIGH_SURR_BASE | 16'($urandom_range(16'h03FF));
  endfunction

  function automatic logic [15:0] rand_low();
    return LOW_SURR_BASE | 16'($urandom_range(16'h03FF));
  endfunction

  // A \u value of one to three UTF-8 bytes that is never a high surrogate;
  // values that land there are folded into the lone low surrogate range.
  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(3))
      0: v = 16'($urandom_range(16'h007F));
      1: v = 16'($urandom_range(16'h07FF, 16'h0080));
      2: v = 16'($urandom_range(16'hFFFF, 16'h0800));
      default: v = rand_low();
    endcase
    if ((v & SURR_MASK) == HIGH_SURR_BASE) v = v | 16'h0400;
    return v;
  endfunction

  // Mostly well-formed string content, with broken surrogate pairs and noise.
  task automatic add_random_items(input int count);
    int goal;
    int pick;
    logic [15:0] v;
    goal = gen_count + count;
    while (gen_count < goal) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        push_byte(text_byte());
      end else if (pick < 42) begin
        push_byte(CH_BSLASH);
        case ($urandom_range(9))
          0: push_byte(CH_N);
          1: push_byte(CH_R);
          2: push_byte(CH_T);
          3: push_byte(CH_F);
          4: push_byte(CH_B);
          5: push_byte(CH_QUOTE);
          6: push_byte(CH_BSLASH);
          default: begin
            v = 16'($urandom_range(255));
            if (v[7:0] == CH_U) v = 16'h002F;
            push_byte(v[7:0]);
          end
        endcase
      end else if (pick < 62) begin
        push_escape_u(rand_bmp(), 1'b1);
      end else if (pick < 76) begin
        push_escape_u(rand_high(), 1'b0);
        push_escape_u(rand_low(), 1'b0);
      end else if (pick < 81) begin
        push_byte(CH_QUOTE);
      end else if (pick < 92) begin
        push_escape_u(rand_high(), 1'b0);
        case ($urandom_range(3))
          0: begin
            push_byte(text_byte());
            push_junk_to_quote();
          end
          1: push_byte(CH_QUOTE);
          2: begin
            push_byte(CH_BSLASH);
            v = 16'($urandom_range(255));
            if (v[7:0] == CH_U) v = 16'h0022;
            push_byte(v[7:0]);
            if (v[7:0] != CH_QUOTE) push_junk_to_quote();
            else push_byte(CH_QUOTE);
          end
          default: begin
            v = 16'($urandom);
            if ((v & SURR_MASK) == LOW_SURR_BASE) v = v ^ 16'h8000;
            push_escape_u(v, 1'b0);
            push_junk_to_quote();
          end
        endcase
      end else begin
        push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver, receiver and monitor
  // --------------------------------------------------------------------------

  // The sender holds an offered byte until its transaction has gone through,
  // then either offers the next pending byte or idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      drv_valid = 1'b0;
      drv_byte  = 8'h00;
    end else if (in_ch.valid && !in_taken) begin
      drv_valid = 1'b1;
      drv_byte  = in_ch.in_byte;
    end else if (body_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      drv_valid = 1'b1;
      drv_byte  = body_bytes_q.pop_front();
      items_sent++;
    end else begin
      drv_valid = 1'b0;
      drv_byte  = 8'($urandom_range(255));
    end
    in_taken = 1'b0;
    in_ch.valid   <= drv_valid;
    in_ch.in_byte <= drv_byte;
  end

  // The receiver stalls at random, and throughout the long hold-off.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // Input transactions are predicted before output transactions are checked,
  // so a result leaving in the same cycle still finds its expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      sc_mode   = MODE_PLAIN;
      sc_accum  = '0;
      sc_digits = '0;
      sc_high   = '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        decode_byte(in_ch.in_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: out_byte %02h kind %0d last %0b",
                 out_ch.out_byte, out_ch.kind, out_ch.last);
          n_errors++;
        end else begin
          result_t r;
          r = decoded_q.pop_front();
          if (out_ch.out_byte !== r.data) begin
            $error("out_byte mismatch: expected %02h, actual %02h", r.data, out_ch.out_byte);
            n_errors++;
          end
          if (out_ch.kind !== r.kind) begin
            $error("kind mismatch: expected %0d, actual %0d", r.kind, out_ch.kind);
            n_errors++;
          end
          if (out_ch.last !== r.last) begin
            $error("last mismatch: expected %0b, actual %0b", r.last, out_ch.last);
            n_errors++;
          end
        end
      end
    end
  end

  // Once the sender is well into the unthrottled part, the receiver holds off
  // long enough for the packet queue to fill and the input to stall.
  initial begin
    @(posedge rst_n);
    while (items_sent < 60) @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // Guard against a hang.
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, with no random idling on either side.
    // Extremes of the byte in plain text.
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_byte(8'h80);
    // Every control escape, escaped quote, backslash and slash, then other
    // escaped bytes, which pass through.
    push_str("\\n\\r\\t\\f\\b\\\"\\\\\\/\\x");
    push_byte(CH_BSLASH);
    push_byte(8'hFF);
    // UTF-8 of one, two and three bytes at the range boundaries.
    push_str("\\u0041\\u00e9\\u07FF\\u0800\\uFFFF\\u0000");
    // Surrogate pairs, including the extremes, and a lone low surrogate.
    push_str("\\uD83D\\uDE00\\udbff\\udfff\\uD800\\uDC00\\uDC00");
    // Stray bytes inside a hex group count as zero; the quote does not end
    // the string there.
    push_str("\\u0\"4G");
    // Missing low surrogate: a plain byte, then discarding in which an
    // escape is not honoured, so the quote after the backslash ends it.
    push_str("\\uD800x\\\"ab\"");
    // Missing low surrogate on a quote, which also ends the string.
    push_str("\\uD800\"");
    // Backslash followed by something other than u, also by a quote.
    push_str("\\uD800\\q\\\"\"");
    push_str("\\uD800\\\"\"");
    // Invalid low surrogate, then discarding up to the quote.
    push_str("\\uD800\\u0041zz\"");
    push_byte(CH_QUOTE);

    // Random part in four idling phases; the first has no idling at all.
    add_random_items(60);
    while (body_bytes_q.size() != 0) @(posedge clk);

    send_idle_pct  = 75;
    recv_stall_pct = 0;
    add_random_items(60);
    while (body_bytes_q.size() != 0) @(posedge clk);

    send_idle_pct  = 0;
    recv_stall_pct = 75;
    add_random_items(60);
    while (body_bytes_q.size() != 0) @(posedge clk);

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    add_random_items(60);

    // Drain: every byte accepted, every result in, then a last wait in which
    // no further result may appear.
    while (body_bytes_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/jsu_pkg.sv
rtl/jsu_in_if.sv
rtl/jsu_out_if.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_core.sv
tb/json_string_unescape_utf8_core_tb.sv
